// ===== rtl/integer_to_ascii_radix_defines.svh =====
// ---------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// Shared concurrent assertion forms, sampled on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication
`define ITOA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ITOA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itoa_pkg.sv =====
// ---------------------------------------------------------------------------
// itoa_pkg
// Widths, codes, types and the digit encoding for the radix converter.
// ---------------------------------------------------------------------------
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int VALUE_W    = 32;
    localparam int USED_BITS  = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - USED_BITS);

    localparam int MAX_DIGITS = USED_BITS;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W     = $clog2(VALUE_W);

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  ASCII_UPPER = 8'h41;
    localparam logic [CHAR_W-1:0]  ASCII_LOWER = 8'h61;
    localparam logic [DIGIT_W-1:0] DEC_DIGITS  = DIGIT_W'(10);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_WAIT,
        S_READ,
        S_OUT,
        S_ERR
    } state_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [RADIX_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(
        input logic [DIGIT_W-1:0] d,
        input logic               upper
    );
        logic [CHAR_W-1:0] base;
        base = upper ? ASCII_UPPER : ASCII_LOWER;
        if (d < DEC_DIGITS)
            return ASCII_ZERO + CHAR_W'(d);
        else
            return base + CHAR_W'(d - DEC_DIGITS);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/itoa_div.sv =====
// ---------------------------------------------------------------------------
// itoa_div
// Restoring divider, one quotient bit per cycle, remainder below the radix.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_defines.svh"

module itoa_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire itoa_pkg::div_req_t req,
    output      itoa_pkg::div_res_t res
);

    logic                          run_reg, run_next;
    logic                          done_reg, done_next;
    logic [itoa_pkg::STEP_W-1:0]   cnt_reg, cnt_next;
    logic [itoa_pkg::VALUE_W-1:0]  quo_reg, quo_next;
    logic [itoa_pkg::DIGIT_W-1:0]  rem_reg, rem_next;
    logic [itoa_pkg::RADIX_W-1:0]  div_reg, div_next;

    logic [itoa_pkg::DIGIT_W:0]    rem_sh;
    logic                          ge;
    logic [itoa_pkg::DIGIT_W-1:0]  rem_step;

    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[itoa_pkg::VALUE_W-1]};
        ge       = (rem_sh >= {1'b0, div_reg});
        rem_step = ge ? itoa_pkg::DIGIT_W'(rem_sh - {1'b0, div_reg})
                      : rem_sh[itoa_pkg::DIGIT_W-1:0];
    end

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = req.dividend;
            rem_next = '0;
            div_next = req.divisor;
        end
        else if (run_reg)
        begin
            quo_next = {quo_reg[itoa_pkg::VALUE_W-2:0], ge};
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == itoa_pkg::STEP_W'(itoa_pkg::VALUE_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

    `ITOA_ASSERT_NEXT(a_div_done_after_last, run_reg && !req.start && (cnt_reg == itoa_pkg::STEP_W'(itoa_pkg::VALUE_W - 1)), done_reg, "divider missed done")
    `ITOA_ASSERT_NEXT(a_div_done_pulse, done_reg && !req.start, !done_reg && !run_reg, "divider done not a pulse")
    `ITOA_ASSERT_SAME(a_div_rem_range, done_reg, rem_reg < div_reg, "remainder not below divisor")

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_radix.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// Unsigned value to ASCII digits in radix 2..36, most significant first.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+------------------------------
//   input    | start, busy                | value, radix, upper_case
//   result   | strobe (one cycle)         | digit_char, last, error
//
// A conversion of D digits holds busy until its final digit is strobed, in the
// last busy cycle: each digit needs one pass of the shared bit-serial
// divider (load, the bit steps, then done), then each stored digit is read
// back from the digit memory through a read state and an output state.
// A bad radix gives one error transaction in the cycle right after start.
// busy is high from acceptance until the final strobe; start is ignored then.
// Reset clears the sequencer; the receiver cannot stall the result strobe.
// ---------------------------------------------------------------------------
`default_nettype none

`include "integer_to_ascii_radix_defines.svh"

module integer_to_ascii_radix (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [itoa_pkg::VALUE_W-1:0]  value,
    input  wire logic [itoa_pkg::RADIX_W-1:0]  radix,
    input  wire logic                          upper_case,
    output      logic                          busy,
    output      logic                          strobe,
    output      logic [itoa_pkg::CHAR_W-1:0]   digit_char,
    output      logic                          last,
    output      logic                          error
);

    itoa_pkg::state_t                state_reg, state_next;
    logic [itoa_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [itoa_pkg::VALUE_W-1:0]    working_reg, working_next;
    logic [itoa_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [itoa_pkg::RADIX_W-1:0]    radix_reg, radix_next;
    logic                            upper_reg, upper_next;
    logic [itoa_pkg::DIGIT_W-1:0]    rd_data_reg;
    logic [itoa_pkg::DIGIT_W-1:0]    digit_mem [itoa_pkg::MAX_DIGITS];

    logic                            mem_we;
    logic                            mem_re;
    logic                            div_start;
    itoa_pkg::div_req_t              div_req;
    itoa_pkg::div_res_t              div_res;

    assign div_req.start    = div_start;
    assign div_req.dividend = working_reg;
    assign div_req.divisor  = radix_reg;

    itoa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        working_next = working_reg;
        idx_next     = idx_reg;
        radix_next   = radix_reg;
        upper_next   = upper_reg;
        div_start    = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        strobe       = 1'b0;
        digit_char   = '0;
        last         = 1'b0;
        error        = 1'b0;
        unique case (state_reg)
            itoa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    if (radix < itoa_pkg::MIN_RADIX || radix > itoa_pkg::MAX_RADIX)
                        state_next = itoa_pkg::S_ERR;
                    else
                    begin
                        working_next = value & itoa_pkg::VALUE_MASK;
                        count_next   = '0;
                        radix_next   = radix;
                        upper_next   = upper_case;
                        state_next   = itoa_pkg::S_LOAD;
                    end
                end
            end
            itoa_pkg::S_LOAD:
            begin
                div_start  = 1'b1;
                state_next = itoa_pkg::S_WAIT;
            end
            itoa_pkg::S_WAIT:
            begin
                if (div_res.done)
                begin
                    mem_we       = 1'b1;
                    count_next   = count_reg + 1'b1;
                    working_next = div_res.quotient;
                    if (div_res.quotient == '0 ||
                        count_next == itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS))
                    begin
                        idx_next   = count_reg[itoa_pkg::IDX_W-1:0];
                        state_next = itoa_pkg::S_READ;
                    end
                    else
                        state_next = itoa_pkg::S_LOAD;
                end
            end
            itoa_pkg::S_READ:
            begin
                mem_re     = 1'b1;
                state_next = itoa_pkg::S_OUT;
            end
            itoa_pkg::S_OUT:
            begin
                strobe     = 1'b1;
                digit_char = itoa_pkg::digit_to_ascii(rd_data_reg, upper_reg);
                last       = (idx_reg == '0);
                if (idx_reg == '0)
                    state_next = itoa_pkg::S_IDLE;
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = itoa_pkg::S_READ;
                end
            end
            itoa_pkg::S_ERR:
            begin
                strobe     = 1'b1;
                last       = 1'b1;
                error      = 1'b1;
                state_next = itoa_pkg::S_IDLE;
            end
            default:
                state_next = itoa_pkg::S_IDLE;
        endcase
    end

    assign busy = (state_reg != itoa_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= itoa_pkg::S_IDLE;
            count_reg   <= '0;
            working_reg <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            working_reg <= working_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        radix_reg <= radix_next;
        upper_reg <= upper_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            digit_mem[count_reg[itoa_pkg::IDX_W-1:0]] <= div_res.remainder;
        if (mem_re)
            rd_data_reg <= digit_mem[idx_reg];
    end

    `ITOA_ASSERT_NEXT(a_error_single, strobe && error, !busy,
                      "error transaction not single")
    `ITOA_ASSERT_NEXT(a_last_ends_item, strobe && last, !busy,
                      "busy after final digit")
    `ITOA_ASSERT_SAME(a_done_in_wait, div_res.done, state_reg == itoa_pkg::S_WAIT,
                      "divider done outside wait")
    `ITOA_ASSERT_SAME(a_count_bound, busy,
                      count_reg <= itoa_pkg::CNT_W'(itoa_pkg::MAX_DIGITS),
                      "digit count overflow")

endmodule

`default_nettype wire
